>>> rtl/hall_wheel_speed_meter_macros.svh
// Assertion macros used by the wheel speed meter checker
`ifndef HALL_WHEEL_SPEED_METER_MACROS_SVH
`define HALL_WHEEL_SPEED_METER_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset
`define HWSM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hwsm assertion failed");

// Next-cycle implication, sampled on clock, off during reset
`define HWSM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hwsm assertion failed");

`endif

>>> rtl/hwsm_pkg.sv
// Types and constants of the hall wheel speed meter
`default_nettype none
package hwsm_pkg;

   localparam int TIME_W     = 32;
   localparam int STAMP_W    = 32;
   localparam int DIST_W     = 20;
   localparam int MIN_W      = 20;
   localparam int TOUT_W     = 32;
   localparam int PERIOD_W   = 32;
   localparam int COUNT_W    = 32;
   localparam int DIR_W      = 2;
   localparam int SPEED_W    = 31;
   localparam int MM_SCALE   = 1000;
   // dist * 1000 stays below 2^30 for a 20-bit distance
   localparam int NUM_W      = 30;
   localparam int STEP_CNT_W = $clog2(NUM_W + 1);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_BITS   = 3 + DIR_W + COUNT_W + COUNT_W + PERIOD_W + SPEED_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [DIST_W-1:0] DIST_RESET     = DIST_W'(73827);
   localparam logic [MIN_W-1:0]  MIN_RESET      = MIN_W'(1500);
   localparam logic [TOUT_W-1:0] TOUT_MIN_RESET = TOUT_W'(500000);
   localparam logic [TOUT_W-1:0] TOUT_MAX_RESET = TOUT_W'(4000000);

   localparam logic [DIR_W-1:0] DIR_NONE = 2'b00;
   localparam logic [DIR_W-1:0] DIR_POS  = 2'b01;
   localparam logic [DIR_W-1:0] DIR_NEG  = 2'b11;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_DIST     = 3'd0,
      CSR_MIN_INT  = 3'd1,
      CSR_TOUT_MIN = 3'd2,
      CSR_TOUT_MAX = 3'd3,
      CSR_DIR_INV  = 3'd4
   } csr_addr_type;

   typedef enum logic {
      OP_EDGE  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_CHECK,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                start;
      logic [DIST_W-1:0]   dist_um;
      logic [PERIOD_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

>>> rtl/hall_wheel_speed_meter.sv
// Hall wheel speed meter top level: edge filter, state, timeout and speed sequencer
//
//   channel   dir   ports                          content
//   req       in    req_tvalid/tready/tdata/tuser  edge or query with timestamp
//   rsp       out   rsp_tvalid/tready/tdata        status, totals, period, speed
//   csr       in    csr_wen/csr_addr/csr_wdata     five setup registers
//
// An edge item, or a query without a speed, runs through the exec, check and emit
// states; a query that yields a speed also waits in the div state on the 30-step
// serial divider. A new request is taken only in the idle state, while an earlier
// result may still wait in the output register. A stalled result holds the block
// before its output load. Sync reset restores totals, state and setup registers.
`default_nettype none
module hall_wheel_speed_meter (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   // [31:0] time_us, [32] dir_level, rest zero
   input  wire logic [hwsm_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] operation
   input  wire logic                            req_tuser,
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [0] edge_accepted, [1] speed ok flag, [2] stale flag, [4:3] direction,
   // [36:5] event_total, [68:37] fault_total, [100:69] period_us,
   // [131:101] speed_mm_s, rest zero
   output      logic [hwsm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                            csr_wen,
   input  wire logic [hwsm_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [hwsm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import hwsm_pkg::*;

   // setup registers
   logic [DIST_W-1:0] dist_ff;
   logic [MIN_W-1:0]  min_ff;
   logic [TOUT_W-1:0] tmin_ff;
   logic [TOUT_W-1:0] tmax_ff;
   logic              inv_ff;

   // meter state
   state_type           state_ff, state_in;
   logic [TIME_W-1:0]   last_time_ff, last_time_in;
   logic                seen_ff, seen_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [DIR_W-1:0]    dir_ff, dir_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [COUNT_W-1:0]  glitch_ff, glitch_in;

   // current request and work values
   op_type              op_ff, op_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic                level_ff, level_in;
   logic [TIME_W-1:0]   elapsed_ff, elapsed_in;
   logic [TOUT_W:0]     limit_ff, limit_in;
   logic                acc_ff, acc_in;
   logic                valid_ff, valid_in;
   logic                tout_ff, tout_in;
   logic                use_div_ff, use_div_in;

   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [63:0]         elapsed_ext;
   logic [PERIOD_W-1:0] elapsed_sat;
   logic [TOUT_W:0]     twice;
   logic [TOUT_W:0]     lim_lo;
   logic [TOUT_W:0]     lim;
   logic                dir_neg;
   logic [SPEED_W-1:0]  mag;
   logic [SPEED_W-1:0]  speed;

   assign elapsed_ext = 64'(elapsed_ff);
   assign elapsed_sat = (|elapsed_ext[63:32]) ? '1 : elapsed_ext[31:0];
   assign twice       = {period_ff, 1'b0};
   // raise to the lower clamp first, then lower to the upper one
   assign lim_lo      = (twice < {1'b0, tmin_ff}) ? {1'b0, tmin_ff} : twice;
   assign lim         = (lim_lo > {1'b0, tmax_ff}) ? {1'b0, tmax_ff} : lim_lo;
   // pin is active low
   assign dir_neg     = (~level_ff) ^ inv_ff;
   assign mag         = SPEED_W'(div_rsp.quotient);
   assign speed       = use_div_ff ? (dir_ff[1] ? SPEED_W'(-mag) : mag) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff <= DIST_RESET;
         min_ff  <= MIN_RESET;
         tmin_ff <= TOUT_MIN_RESET;
         tmax_ff <= TOUT_MAX_RESET;
         inv_ff  <= 1'b0;
      end else if (csr_wen) begin
         unique case (csr_addr)
            CSR_DIST:     dist_ff <= csr_wdata[DIST_W-1:0];
            CSR_MIN_INT:  min_ff  <= csr_wdata[MIN_W-1:0];
            CSR_TOUT_MIN: tmin_ff <= csr_wdata[TOUT_W-1:0];
            CSR_TOUT_MAX: tmax_ff <= csr_wdata[TOUT_W-1:0];
            CSR_DIR_INV:  inv_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      last_time_in  = last_time_ff;
      seen_in       = seen_ff;
      period_in     = period_ff;
      dir_in        = dir_ff;
      count_in      = count_ff;
      glitch_in     = glitch_ff;
      op_in         = op_ff;
      now_in        = now_ff;
      level_in      = level_ff;
      elapsed_in    = elapsed_ff;
      limit_in      = limit_ff;
      acc_in        = acc_ff;
      valid_in      = valid_ff;
      tout_in       = tout_ff;
      use_div_in    = use_div_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      div_req.start   = 1'b0;
      div_req.dist_um = dist_ff;
      div_req.divisor = period_ff;
      req_tready      = 1'b0;

      // drop a result once taken
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               op_in    = op_type'(req_tuser);
               now_in   = TIME_W'(req_tdata[STAMP_W-1:0]);
               level_in = req_tdata[STAMP_W];
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            elapsed_in = now_ff - last_time_ff;
            limit_in   = lim;
            state_in   = ST_CHECK;
         end
         ST_CHECK: begin
            acc_in     = 1'b0;
            valid_in   = 1'b0;
            tout_in    = 1'b0;
            use_div_in = 1'b0;
            state_in   = ST_EMIT;
            if (op_ff == OP_EDGE) begin
               if (seen_ff && (elapsed_ext < 64'(min_ff))) begin
                  glitch_in = glitch_ff + 1'b1;
               end else begin
                  if (seen_ff) begin
                     period_in = elapsed_sat;
                  end
                  last_time_in = now_ff;
                  seen_in      = 1'b1;
                  dir_in       = dir_neg ? DIR_NEG : DIR_POS;
                  count_in     = count_ff + (dir_neg ? '1 : COUNT_W'(1));
                  acc_in       = 1'b1;
               end
            end else begin
               if ((period_ff == '0) || !seen_ff) begin
                  tout_in = 1'b1;
               end else if (elapsed_ext > 64'(limit_ff)) begin
                  tout_in = 1'b1;
               end else begin
                  valid_in = 1'b1;
                  if (dir_ff != DIR_NONE) begin
                     use_div_in    = 1'b1;
                     div_req.start = 1'b1;
                     state_in      = ST_DIV;
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = RSP_DATA_W'({speed, period_ff, glitch_ff, count_ff,
                                            dir_ff, tout_ff, valid_ff, acc_ff});
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_time_ff  <= '0;
         seen_ff       <= 1'b0;
         period_ff     <= '0;
         dir_ff        <= DIR_NONE;
         count_ff      <= '0;
         glitch_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_time_ff  <= last_time_in;
         seen_ff       <= seen_in;
         period_ff     <= period_in;
         dir_ff        <= dir_in;
         count_ff      <= count_in;
         glitch_ff     <= glitch_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      now_ff       <= now_in;
      level_ff     <= level_in;
      elapsed_ff   <= elapsed_in;
      limit_ff     <= limit_in;
      acc_ff       <= acc_in;
      valid_ff     <= valid_in;
      tout_ff      <= tout_in;
      use_div_ff   <= use_div_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   hwsm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
`default_nettype wire

>>> rtl/hwsm_div.sv
// Restoring serial divider: distance times 1000 over the period, one bit a cycle
`default_nettype none
module hwsm_div (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire hwsm_pkg::div_req_type div_req,
   output hwsm_pkg::div_rsp_type    div_rsp
);
   import hwsm_pkg::*;

   logic                  busy_ff;
   logic                  done_ff;
   logic [STEP_CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0]      quo_ff;
   logic [PERIOD_W-1:0]   rem_ff;
   logic [PERIOD_W-1:0]   div_ff;
   logic [PERIOD_W:0]     trial;
   logic                  fits;

   // shift the next dividend bit into the partial remainder
   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign fits  = (trial >= {1'b0, div_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= STEP_CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == STEP_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         quo_ff <= NUM_W'(NUM_W'(div_req.dist_um) * NUM_W'(MM_SCALE));
         rem_ff <= '0;
         div_ff <= div_req.divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
         rem_ff <= fits ? PERIOD_W'(trial - {1'b0, div_ff}) : trial[PERIOD_W-1:0];
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
`default_nettype wire

>>> rtl/hwsm_checker.sv
// Port-level checker of the hall wheel speed meter and its bind
`default_nettype none
`include "hall_wheel_speed_meter_macros.svh"
module hwsm_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [hwsm_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import hwsm_pkg::*;

   // a stalled result holds its payload
   `HWSM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // one request at a time: busy right after an accept
   `HWSM_ASSERT_NXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready)
   // valid speed and timeout never together
   `HWSM_ASSERT_IMP(a_flags_excl, clock, reset, rsp_tvalid, !(rsp_tdata[1] && rsp_tdata[2]))
   // no speed unless reported valid
   `HWSM_ASSERT_IMP(a_speed_zero, clock, reset, rsp_tvalid && !rsp_tdata[1], rsp_tdata[131:101] == '0)

endmodule

bind hall_wheel_speed_meter hwsm_checker u_hwsm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
